// ----- src/ufl_pkg.sv -----
// shared types, constants and codes for the ultrasonic fill level classifier
package ufl_pkg;

    // field widths
    localparam int ECHO_W  = 15;
    localparam int CM_W    = 9;
    localparam int PCT_W   = 7;
    localparam int CLASS_W = 3;
    localparam int BLINK_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    // serial divider sizes: echo*17 fits in 20 bits, divisor 1000 needs 10
    localparam int DIV_W  = 20;
    localparam int DVSR_W = 10;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // conversion constants: 0.034 / 2 cm per us = 17 / 1000
    localparam int unsigned ECHO_DIVISOR = 1000;
    localparam int unsigned FULL_PERCENT = 100;
    localparam int unsigned MEDIUM_LEVEL = 50;
    localparam int unsigned LOW_LEVEL    = 25;

    // default samples averaged per reading
    localparam int SAMPLES_DEFAULT = 5;

    // register reset values
    localparam logic [CM_W-1:0]  BIN_HEIGHT_RST = 9'd100;
    localparam logic [CM_W-1:0]  MAX_DIST_RST   = 9'd400;
    localparam logic [PCT_W-1:0] FULL_THR_RST   = 7'd90;
    localparam logic [PCT_W-1:0] NEAR_THR_RST   = 7'd75;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIN_HEIGHT = 2'd0,
        REG_MAX_DIST   = 2'd1,
        REG_FULL_THR   = 2'd2,
        REG_NEAR_THR   = 2'd3
    } cfg_idx_t;

    // fill classes
    typedef enum logic [CLASS_W-1:0] {
        CLASS_EMPTY  = 3'd0,
        CLASS_LOW    = 3'd1,
        CLASS_MEDIUM = 3'd2,
        CLASS_NEAR   = 3'd3,
        CLASS_FULL   = 3'd4
    } fill_class_t;

    // alert led modes
    typedef enum logic [BLINK_W-1:0] {
        BLINK_OFF  = 2'd0,
        BLINK_SLOW = 2'd1,
        BLINK_FAST = 2'd2
    } blink_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_CONV = 3'd1,
        ST_AVG  = 3'd2,
        ST_FILL = 3'd3
    } state_t;

    // classification result handed to the top level
    typedef struct packed {
        fill_class_t cls;
        logic        changed;
        logic        alert;
        blink_t      blink;
    } class_info_t;

endpackage

// ----- src/ultrasonic_fill_level_classifier_unit.sv -----
// top level: echo conversion, averaging, fill percent and classification
//
//  channel   handshake             payload
//  echo      echo_valid/stall      echo_time_us
//  result    result_valid/stall    distance_cm fill_percent fill_class
//                                  class_changed alert blink_mode
//  cfg       cfg_valid/ready       cfg_index cfg_data
//
// a sample takes the accept cycle, 20 steps of the serial divider
// for echo*17/1000, then a clip and accumulate step.
// the last sample of a reading adds two more divider passes
// (sum by sample count, then percent by bin height).
// the one shared divider serves all passes, one bit per cycle.
// reset clears the count, the sum, the last class and restores the registers.
// a stalled result holds in the output register while the next samples
// are taken; only the final load of a reading waits for it to drain.
module ultrasonic_fill_level_classifier_unit #(
    parameter int SAMPLES_PER_READING = ufl_pkg::SAMPLES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // echo channel
    input  logic                          echo_valid,
    output logic                          echo_stall,
    input  logic [ufl_pkg::ECHO_W-1:0]    echo_time_us,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ufl_pkg::CM_W-1:0]      distance_cm,
    output logic [ufl_pkg::PCT_W-1:0]     fill_percent,
    output logic [ufl_pkg::CLASS_W-1:0]   fill_class,
    output logic                          class_changed,
    output logic                          alert,
    output logic [ufl_pkg::BLINK_W-1:0]   blink_mode,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ufl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ufl_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);
    localparam int SUM_W = ufl_pkg::CM_W + $clog2(SAMPLES_PER_READING);
    localparam int NUM_W = 16;

    // configuration registers
    logic [ufl_pkg::CM_W-1:0]  bin_depth_reg;
    logic [ufl_pkg::CM_W-1:0]  max_dist_reg;
    logic [ufl_pkg::PCT_W-1:0] full_thr_reg;
    logic [ufl_pkg::PCT_W-1:0] near_thr_reg;

    // sequencer and accumulator state
    ufl_pkg::state_t           state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    ufl_pkg::fill_class_t      last_class_reg, last_class_next;
    logic                      zero_fill_reg, zero_fill_next;
    logic [ufl_pkg::CM_W-1:0]  avg_reg, avg_next;

    // output register
    logic                      res_valid_reg, res_valid_next;
    logic [ufl_pkg::CM_W-1:0]  res_dist_reg, res_dist_next;
    logic [ufl_pkg::PCT_W-1:0] res_pct_reg, res_pct_next;
    ufl_pkg::class_info_t      res_info_reg, res_info_next;

    // divider hookup
    logic                         div_start;
    logic [ufl_pkg::DIV_W-1:0]    div_dividend;
    logic [ufl_pkg::DVSR_W-1:0]   div_divisor;
    logic                         div_busy;
    logic [ufl_pkg::DIV_W-1:0]    div_quotient;

    // datapath helpers
    logic [ufl_pkg::DIV_W-1:0]    echo_x17;
    logic [ufl_pkg::DVSR_W-1:0]   dist_raw;
    logic [ufl_pkg::CM_W-1:0]     dist_valid;
    logic [ufl_pkg::CM_W-1:0]     dist_clip;
    logic [SUM_W-1:0]             sum_total;
    logic [ufl_pkg::CM_W-1:0]     avg_now;
    logic [ufl_pkg::CM_W-1:0]     head_room;
    logic [NUM_W-1:0]             fill_num;
    logic [ufl_pkg::PCT_W-1:0]    level;
    logic                         out_free;
    ufl_pkg::class_info_t         cls_info;

    // echo time times 17
    assign echo_x17 = {1'b0, echo_time_us, 4'b0000} + ufl_pkg::DIV_W'(echo_time_us);

    // replace invalid readings, then clip to bin height
    always_comb
    begin
        dist_raw   = div_quotient[ufl_pkg::DVSR_W-1:0];
        dist_valid = ((dist_raw == '0) || (dist_raw > {1'b0, max_dist_reg}))
                   ? max_dist_reg : dist_raw[ufl_pkg::CM_W-1:0];
        dist_clip  = (dist_valid > bin_depth_reg) ? bin_depth_reg : dist_valid;
        sum_total  = sum_reg + SUM_W'(dist_clip);
    end

    // fill numerator (height - avg) * 100 as shifts
    always_comb
    begin
        avg_now   = div_quotient[ufl_pkg::CM_W-1:0];
        head_room = bin_depth_reg - avg_now;
        fill_num  = {1'b0, head_room, 6'b000000} + {2'b00, head_room, 5'b00000}
                  + {5'b00000, head_room, 2'b00};
    end

    // percent from the divider, clamped, forced to zero when out of range
    always_comb
    begin
        if (zero_fill_reg)
        begin
            level = '0;
        end
        else if (div_quotient > ufl_pkg::DIV_W'(ufl_pkg::FULL_PERCENT))
        begin
            level = ufl_pkg::PCT_W'(ufl_pkg::FULL_PERCENT);
        end
        else
        begin
            level = div_quotient[ufl_pkg::PCT_W-1:0];
        end
    end

    // classification
    ufl_class u_class (
        .level      (level),
        .full_thr   (full_thr_reg),
        .near_thr   (near_thr_reg),
        .last_class (last_class_reg),
        .info       (cls_info)
    );

    // shared serial divider
    ufl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign out_free = !res_valid_reg || !result_stall;

    // sequencer next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        last_class_next = last_class_reg;
        zero_fill_next  = zero_fill_reg;
        avg_next        = avg_reg;
        res_valid_next  = res_valid_reg && result_stall;
        res_dist_next   = res_dist_reg;
        res_pct_next    = res_pct_reg;
        res_info_next   = res_info_reg;
        div_start       = 1'b0;
        div_dividend    = echo_x17;
        div_divisor     = ufl_pkg::DVSR_W'(ufl_pkg::ECHO_DIVISOR);
        echo_stall      = 1'b1;

        unique case (state_reg)
            ufl_pkg::ST_IDLE:
            begin
                echo_stall = 1'b0;
                if (echo_valid)
                begin
                    div_start  = 1'b1;
                    state_next = ufl_pkg::ST_CONV;
                end
            end
            ufl_pkg::ST_CONV:
            begin
                if (!div_busy)
                begin
                    if (count_reg == CNT_W'(SAMPLES_PER_READING - 1))
                    begin
                        count_next   = '0;
                        sum_next     = '0;
                        div_start    = 1'b1;
                        div_dividend = ufl_pkg::DIV_W'(sum_total);
                        div_divisor  = ufl_pkg::DVSR_W'(SAMPLES_PER_READING);
                        state_next   = ufl_pkg::ST_AVG;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_total;
                        state_next = ufl_pkg::ST_IDLE;
                    end
                end
            end
            ufl_pkg::ST_AVG:
            begin
                if (!div_busy)
                begin
                    avg_next       = avg_now;
                    zero_fill_next = (bin_depth_reg == '0) || (avg_now > bin_depth_reg);
                    div_start      = 1'b1;
                    div_dividend   = ufl_pkg::DIV_W'(fill_num);
                    div_divisor    = ufl_pkg::DVSR_W'(bin_depth_reg);
                    state_next     = ufl_pkg::ST_FILL;
                end
            end
            ufl_pkg::ST_FILL:
            begin
                if (!div_busy && out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_dist_next   = avg_reg;
                    res_pct_next    = level;
                    res_info_next   = cls_info;
                    last_class_next = cls_info.cls;
                    state_next      = ufl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ufl_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ufl_pkg::ST_IDLE;
            count_reg      <= '0;
            sum_reg        <= '0;
            last_class_reg <= ufl_pkg::CLASS_EMPTY;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            last_class_reg <= last_class_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // result payload and scratch values
    always_ff @(posedge clk)
    begin
        zero_fill_reg <= zero_fill_next;
        avg_reg       <= avg_next;
        res_dist_reg  <= res_dist_next;
        res_pct_reg   <= res_pct_next;
        res_info_reg  <= res_info_next;
    end

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_depth_reg  <= ufl_pkg::BIN_HEIGHT_RST;
            max_dist_reg   <= ufl_pkg::MAX_DIST_RST;
            full_thr_reg   <= ufl_pkg::FULL_THR_RST;
            near_thr_reg   <= ufl_pkg::NEAR_THR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (ufl_pkg::cfg_idx_t'(cfg_index))
                ufl_pkg::REG_BIN_HEIGHT: bin_depth_reg  <= cfg_data;
                ufl_pkg::REG_MAX_DIST:   max_dist_reg   <= cfg_data;
                ufl_pkg::REG_FULL_THR:   full_thr_reg   <= cfg_data[ufl_pkg::PCT_W-1:0];
                ufl_pkg::REG_NEAR_THR:   near_thr_reg   <= cfg_data[ufl_pkg::PCT_W-1:0];
                default:                 bin_depth_reg  <= bin_depth_reg;
            endcase
        end
    end

    // port drive
    assign cfg_ready     = 1'b1;
    assign result_valid  = res_valid_reg;
    assign distance_cm   = res_dist_reg;
    assign fill_percent  = res_pct_reg;
    assign fill_class    = res_info_reg.cls;
    assign class_changed = res_info_reg.changed;
    assign alert         = res_info_reg.alert;
    assign blink_mode    = res_info_reg.blink;

    // an accepted word always starts the divider
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (echo_valid && !echo_stall) |=> div_busy)
        else $error("accepted echo word did not start the divider");

    // a new result only comes out of the percent pass
    a_result_from_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_next && !(res_valid_reg && result_stall)) |->
        (state_reg == ufl_pkg::ST_FILL && !div_busy))
        else $error("result loaded outside the percent pass");

    // sample count stays inside one reading
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SAMPLES_PER_READING - 1))
        else $error("sample count beyond one reading");

    // reported class is remembered for the next change test
    a_last_class: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ufl_pkg::ST_FILL && state_next == ufl_pkg::ST_IDLE) |=>
        (last_class_reg == res_info_reg.cls))
        else $error("last class not updated with reported class");

endmodule

// ----- src/ufl_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module ufl_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ufl_pkg::DIV_W-1:0]  dividend,
    input  logic [ufl_pkg::DVSR_W-1:0] divisor,
    output logic                      busy,
    output logic [ufl_pkg::DIV_W-1:0]  quotient
);

    logic                            busy_reg, busy_next;
    logic [ufl_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ufl_pkg::DIV_W-1:0]       quo_reg, quo_next;
    logic [ufl_pkg::DVSR_W-1:0]      rem_reg, rem_next;
    logic [ufl_pkg::DVSR_W-1:0]      dvsr_reg, dvsr_next;
    logic [ufl_pkg::DVSR_W:0]        trial;
    logic [ufl_pkg::DVSR_W:0]        diff;
    logic                            fits;

    // one restoring step: shift next dividend bit into the remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[ufl_pkg::DIV_W-1]};
        diff  = trial - {1'b0, dvsr_reg};
        fits  = (trial >= {1'b0, dvsr_reg});
    end

    // next state of the divider
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ufl_pkg::DIV_CNT_W'(ufl_pkg::DIV_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[ufl_pkg::DIV_W-2:0], fits};
            rem_next = fits ? diff[ufl_pkg::DVSR_W-1:0] : trial[ufl_pkg::DVSR_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/ufl_class.sv -----
// five-way fill classification, change flag, alert and blink mode
module ufl_class (
    input  logic [ufl_pkg::PCT_W-1:0] level,
    input  logic [ufl_pkg::PCT_W-1:0] full_thr,
    input  logic [ufl_pkg::PCT_W-1:0] near_thr,
    input  ufl_pkg::fill_class_t      last_class,
    output ufl_pkg::class_info_t      info
);

    logic is_full;
    logic is_near;

    // threshold tests shared by class and blink mode
    assign is_full = (level >= full_thr);
    assign is_near = (level >= near_thr);

    // class, change and led mode
    always_comb
    begin
        priority if (is_full)
        begin
            info.cls = ufl_pkg::CLASS_FULL;
        end
        else if (is_near)
        begin
            info.cls = ufl_pkg::CLASS_NEAR;
        end
        else if (level >= ufl_pkg::PCT_W'(ufl_pkg::MEDIUM_LEVEL))
        begin
            info.cls = ufl_pkg::CLASS_MEDIUM;
        end
        else if (level >= ufl_pkg::PCT_W'(ufl_pkg::LOW_LEVEL))
        begin
            info.cls = ufl_pkg::CLASS_LOW;
        end
        else
        begin
            info.cls = ufl_pkg::CLASS_EMPTY;
        end

        priority if (is_full)
        begin
            info.blink = ufl_pkg::BLINK_FAST;
        end
        else if (is_near)
        begin
            info.blink = ufl_pkg::BLINK_SLOW;
        end
        else
        begin
            info.blink = ufl_pkg::BLINK_OFF;
        end

        info.changed = (info.cls != last_class);
        info.alert   = info.changed &&
                       ((info.cls == ufl_pkg::CLASS_NEAR) || (info.cls == ufl_pkg::CLASS_FULL));
    end

endmodule
